FILE: rtl/assert_macros.svh
// Assertion macros shared by the rotary embedding RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rope assertion failed");
`define RASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rope assertion failed");
`else
`define RASSERT(lbl, clk, rst, prop)
`define RASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/rope_pkg.sv
// Shared constants, types and constant tables of the rotary embedding block.
`default_nettype none
package rope_pkg;

  localparam int DATA_W  = 16;
  localparam int POS_W   = 16;
  localparam int IDX_W   = 6;
  localparam int DIMS_W  = 8;
  localparam int THETA_W = 21;

  localparam int MAX_ROTARY_DIMS = 128;
  localparam int MAX_HALF        = MAX_ROTARY_DIMS / 2;
  localparam int HALF_W          = $clog2(MAX_HALF + 1);

  localparam logic [DIMS_W-1:0]  RESET_DIMS  = 8'd128;
  localparam logic [THETA_W-1:0] RESET_THETA = 21'd870824;

  // register indexes of the configuration port
  localparam logic CFG_ROTARY_DIMS = 1'b0;
  localparam logic CFG_THETA_LOG2  = 1'b1;

  // exponent e = theta_log2 * i / half, Q.16
  localparam int E_W         = THETA_W + IDX_W;
  localparam int FRAC_W      = 16;
  localparam int EINT_W      = E_W - FRAC_W;
  localparam int DIV_STEP    = 7;
  localparam int DIV_STAGES  = (E_W + DIV_STEP - 1) / DIV_STEP;

  localparam int M_W = 32;
  localparam int R_W = POS_W + M_W;

  localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;
  localparam logic signed [63:0] TWO_PI_Q28 = 64'sd1686629713;

  // CORDIC datapath
  localparam int CORDIC_STEPS = 16;
  localparam int GUARD_BITS   = (DATA_W < 30) ? 30 - DATA_W : 0;
  localparam int CW           = 34;
  localparam int PROD_W       = CW + 32;
  localparam int DROP         = 30 + GUARD_BITS;
  localparam int RES_W        = PROD_W - DROP;
  localparam logic signed [PROD_W-1:0] GAIN_Q30 = PROD_W'(652032874);
  localparam logic signed [PROD_W-1:0] GAIN_RND = PROD_W'(1) <<< (DROP - 1);

  typedef struct packed {
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic                     last;
  } rope_side_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 last;
  } rope_vec_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] first;
    logic signed [DATA_W-1:0] second;
    logic                     last;
    logic                     clip;
  } rope_res_t;

  typedef logic [FRAC_W-1:0][31:0] exp_c_t;

  // floor square root, bit by bit
  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // c_k = 2^(-2^-(k+1)) in Q1.31, each the floor root of the one before
  function automatic exp_c_t gen_exp_c();
    exp_c_t      t;
    logic [63:0] c;
    c = isqrt64(64'h2000_0000_0000_0000);
    for (int k = 0; k < FRAC_W; k++) begin
      t[k] = c[31:0];
      c    = isqrt64(c << 31);
    end
    return t;
  endfunction

  localparam exp_c_t EXP_C = gen_exp_c();

  // arctan(2^-k) in Q2.30
  function automatic logic signed [CW-1:0] atan_q30(input int k);
    logic signed [CW-1:0] r;
    case (k)
      0:       r = CW'(843314857);
      1:       r = CW'(497837829);
      2:       r = CW'(263043837);
      3:       r = CW'(133525159);
      4:       r = CW'(67021687);
      5:       r = CW'(33543516);
      6:       r = CW'(16775851);
      7:       r = CW'(8388437);
      8:       r = CW'(4194283);
      9:       r = CW'(2097149);
      default: r = CW'(64'sd1 <<< (30 - k));
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/rope_div.sv
// Exponent stage: theta_log2 * i, then restoring division by rotary_dims / 2.
`default_nettype none
module rope_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  rope_pkg::rope_side_t           in_side,
  input  logic [rope_pkg::IDX_W-1:0]     in_index,
  input  logic [rope_pkg::THETA_W-1:0]   theta,
  input  logic [rope_pkg::HALF_W-1:0]    half,
  output logic                           out_valid,
  output rope_pkg::rope_side_t           out_side,
  output logic [rope_pkg::E_W-1:0]       out_e
);
  import rope_pkg::*;

  logic             pv;
  rope_side_t       pside;
  logic [E_W-1:0]   pn;

  logic             dv    [DIV_STAGES];
  rope_side_t       dside [DIV_STAGES];
  logic [HALF_W-1:0] drem [DIV_STAGES];
  logic [E_W-1:0]   dn    [DIV_STAGES];
  logic [E_W-1:0]   dq    [DIV_STAGES];

  // dividend register
  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (en) begin
      pv <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pside <= in_side;
      pn    <= E_W'(theta) * E_W'(in_index);
    end
  end

  // division stages, up to DIV_STEP quotient bits each
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    logic              vi;
    rope_side_t        si;
    logic [HALF_W-1:0] ri;
    logic [E_W-1:0]    ni;
    logic [E_W-1:0]    qi;
    logic [HALF_W-1:0] ro;
    logic [E_W-1:0]    no;
    logic [E_W-1:0]    qo;

    if (s == 0) begin : g_first
      assign vi = pv;
      assign si = pside;
      assign ri = '0;
      assign ni = pn;
      assign qi = '0;
    end else begin : g_next
      assign vi = dv[s-1];
      assign si = dside[s-1];
      assign ri = drem[s-1];
      assign ni = dn[s-1];
      assign qi = dq[s-1];
    end

    always_comb begin : div_steps
      logic [HALF_W:0] sh;
      logic [HALF_W:0] df;
      sh = '0;
      df = '0;
      ro = ri;
      no = ni;
      qo = qi;
      for (int t = 0; t < DIV_STEP; t++) begin
        if (s * DIV_STEP + t < E_W) begin
          sh = {ro, no[E_W-1]};
          no = {no[E_W-2:0], 1'b0};
          df = sh - {1'b0, half};
          if (sh >= {1'b0, half}) begin
            ro = df[HALF_W-1:0];
            qo = {qo[E_W-2:0], 1'b1};
          end else begin
            ro = sh[HALF_W-1:0];
            qo = {qo[E_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[s] <= 1'b0;
      end else if (en) begin
        dv[s] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dside[s] <= si;
        drem[s]  <= ro;
        dn[s]    <= no;
        dq[s]    <= qo;
      end
    end
  end

  assign out_valid = dv[DIV_STAGES-1];
  assign out_side  = dside[DIV_STAGES-1];
  assign out_e     = dq[DIV_STAGES-1];

endmodule
`default_nettype wire

FILE: rtl/rope_exp2.sv
// Frequency stage: 2^(-fraction) as a chain of rounded Q1.31 multiplies.
`default_nettype none
module rope_exp2 (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  rope_pkg::rope_side_t          in_side,
  input  logic [rope_pkg::E_W-1:0]      in_e,
  output logic                          out_valid,
  output rope_pkg::rope_side_t          out_side,
  output logic [rope_pkg::M_W-1:0]      out_m,
  output logic [rope_pkg::EINT_W-1:0]   out_eint
);
  import rope_pkg::*;

  logic              v    [FRAC_W];
  rope_side_t        side [FRAC_W];
  logic [M_W-1:0]    m    [FRAC_W];
  logic [FRAC_W-1:0] ef   [FRAC_W];
  logic [EINT_W-1:0] ei   [FRAC_W];

  // one stage per fraction bit, most significant first
  for (genvar k = 0; k < FRAC_W; k++) begin : g_exp
    logic              vi;
    rope_side_t        si;
    logic [M_W-1:0]    mi;
    logic [FRAC_W-1:0] fi;
    logic [EINT_W-1:0] eii;
    logic [63:0]       prod;
    logic [63:0]       rnd;
    logic [M_W-1:0]    mo;

    if (k == 0) begin : g_first
      assign vi  = in_valid;
      assign si  = in_side;
      assign mi  = M_W'(64'h8000_0000);
      assign fi  = in_e[FRAC_W-1:0];
      assign eii = in_e[E_W-1:FRAC_W];
    end else begin : g_next
      assign vi  = v[k-1];
      assign si  = side[k-1];
      assign mi  = m[k-1];
      assign fi  = ef[k-1];
      assign eii = ei[k-1];
    end

    assign prod = {32'b0, mi} * {32'b0, EXP_C[k]};
    assign rnd  = prod + 64'h4000_0000;
    assign mo   = fi[FRAC_W-1-k] ? rnd[62:31] : mi;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side[k] <= si;
        m[k]    <= mo;
        ef[k]   <= fi;
        ei[k]   <= eii;
      end
    end
  end

  assign out_valid = v[FRAC_W-1];
  assign out_side  = side[FRAC_W-1];
  assign out_m     = m[FRAC_W-1];
  assign out_eint  = ei[FRAC_W-1];

endmodule
`default_nettype wire

FILE: rtl/rope_angle.sv
// Angle stage: radians, turns, quadrant fold and CORDIC start vector.
`default_nettype none
`include "assert_macros.svh"
module rope_angle (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  rope_pkg::rope_side_t          in_side,
  input  logic [rope_pkg::M_W-1:0]      in_m,
  input  logic [rope_pkg::EINT_W-1:0]   in_eint,
  output logic                          out_valid,
  output rope_pkg::rope_vec_t           out_vec
);
  import rope_pkg::*;

  logic v1, v2, v3, v4, v5;
  rope_side_t s1, s2, s3, s4;
  logic [R_W-1:0] p1;
  logic           big1;
  logic [5:0]     sh1;
  logic [R_W-1:0] r2;
  logic [31:0]    ph3;
  logic [31:0]    pl3;
  logic signed [31:0] st4;
  logic           neg4;
  rope_vec_t      vec5;

  logic [62:0]        pl_full;
  logic [31:0]        t_sum;
  logic               fold;
  logic signed [DATA_W:0] a_e;
  logic signed [DATA_W:0] b_e;
  logic signed [DATA_W:0] a_n;
  logic signed [DATA_W:0] b_n;
  logic signed [63:0] st_e;
  logic signed [63:0] zp;

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // position times frequency; exponent beyond 63 gives a zero angle
  always_ff @(posedge clk) begin
    if (en) begin
      s1   <= in_side;
      p1   <= {{(R_W-POS_W){1'b0}}, in_side.pos} * {{(R_W-M_W){1'b0}}, in_m};
      big1 <= |in_eint[EINT_W-1:6];
      sh1  <= in_eint[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2 <= s1;
      r2 <= big1 ? '0 : (p1 >> sh1);
    end
  end

  // radians to turns, high and low halves
  assign pl_full = {32'b0, r2[30:0]} * {31'b0, INV_TWO_PI_Q32};

  always_ff @(posedge clk) begin
    if (en) begin
      s3  <= s2;
      ph3 <= {15'b0, r2[R_W-1:31]} * INV_TWO_PI_Q32;
      pl3 <= pl_full[62:31];
    end
  end

  // fold outer half turn into the CORDIC range by negating the pair
  assign t_sum = ph3 + pl3;
  assign fold  = ($signed(t_sum) > 32'sd1073741824) || ($signed(t_sum) < -32'sd1073741824);

  always_ff @(posedge clk) begin
    if (en) begin
      s4   <= s3;
      neg4 <= fold;
      st4  <= fold ? $signed({~t_sum[31], t_sum[30:0]}) : $signed(t_sum);
    end
  end

  // turns to Q2.30 radians, scaled start vector
  assign a_e  = {s4.a[DATA_W-1], s4.a};
  assign b_e  = {s4.b[DATA_W-1], s4.b};
  assign a_n  = neg4 ? -a_e : a_e;
  assign b_n  = neg4 ? -b_e : b_e;
  assign st_e = {{32{st4[31]}}, st4};
  assign zp   = st_e * TWO_PI_Q28 + 64'sd536870912;

  always_ff @(posedge clk) begin
    if (en) begin
      vec5.x    <= {{(CW-DATA_W-1-GUARD_BITS){a_n[DATA_W]}}, a_n, {GUARD_BITS{1'b0}}};
      vec5.y    <= {{(CW-DATA_W-1-GUARD_BITS){b_n[DATA_W]}}, b_n, {GUARD_BITS{1'b0}}};
      vec5.z    <= zp[30+CW-1:30];
      vec5.last <= s4.last;
    end
  end

  assign out_valid = v5;
  assign out_vec   = vec5;

  // folded angle stays within a quarter turn
  `RASSERT(a_fold_range, clk, rst, v4 |-> (st4 <= 32'sd1073741824 && st4 >= -32'sd1073741824))

endmodule
`default_nettype wire

FILE: rtl/rope_cordic.sv
// CORDIC rotation, one step per stage, then gain, rounding and saturation.
`default_nettype none
module rope_cordic (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  rope_pkg::rope_vec_t   in_vec,
  output logic                  out_valid,
  output rope_pkg::rope_res_t   out_res
);
  import rope_pkg::*;

  localparam logic signed [RES_W-1:0] SAT_HI = RES_W'((64'sd1 <<< (DATA_W - 1)) - 1);
  localparam logic signed [RES_W-1:0] SAT_LO = ~SAT_HI;

  logic      v   [CORDIC_STEPS];
  rope_vec_t vec [CORDIC_STEPS];

  logic              fv;
  logic signed [PROD_W-1:0] fx;
  logic signed [PROD_W-1:0] fy;
  logic              flast;
  logic              ov;
  rope_res_t         ores;

  logic signed [PROD_W-1:0] xe;
  logic signed [PROD_W-1:0] ye;
  logic signed [RES_W-1:0]  rx;
  logic signed [RES_W-1:0]  ry;
  logic                     cx;
  logic                     cy;

  // rotation steps
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    localparam logic signed [CW-1:0] ATAN = atan_q30(k);
    logic                 vi;
    rope_vec_t            vv;
    rope_vec_t            vo;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic                 up;

    if (k == 0) begin : g_first
      assign vi = in_valid;
      assign vv = in_vec;
    end else begin : g_next
      assign vi = v[k-1];
      assign vv = vec[k-1];
    end

    assign dx      = vv.y >>> k;
    assign dy      = vv.x >>> k;
    assign up      = ~vv.z[CW-1];
    assign vo.x    = up ? vv.x - dx : vv.x + dx;
    assign vo.y    = up ? vv.y + dy : vv.y - dy;
    assign vo.z    = up ? vv.z - ATAN : vv.z + ATAN;
    assign vo.last = vv.last;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        vec[k] <= vo;
      end
    end
  end

  // gain correction with half-up rounding constant
  assign xe = {{(PROD_W-CW){vec[CORDIC_STEPS-1].x[CW-1]}}, vec[CORDIC_STEPS-1].x};
  assign ye = {{(PROD_W-CW){vec[CORDIC_STEPS-1].y[CW-1]}}, vec[CORDIC_STEPS-1].y};

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
      ov <= 1'b0;
    end else if (en) begin
      fv <= v[CORDIC_STEPS-1];
      ov <= fv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fx    <= xe * GAIN_Q30 + GAIN_RND;
      fy    <= ye * GAIN_Q30 + GAIN_RND;
      flast <= vec[CORDIC_STEPS-1].last;
    end
  end

  // drop fraction, saturate to the data width
  assign rx = fx[PROD_W-1:DROP];
  assign ry = fy[PROD_W-1:DROP];
  assign cx = (rx > SAT_HI) || (rx < SAT_LO);
  assign cy = (ry > SAT_HI) || (ry < SAT_LO);

  always_ff @(posedge clk) begin
    if (en) begin
      ores.first  <= (rx > SAT_HI) ? SAT_HI[DATA_W-1:0] :
                     (rx < SAT_LO) ? SAT_LO[DATA_W-1:0] : rx[DATA_W-1:0];
      ores.second <= (ry > SAT_HI) ? SAT_HI[DATA_W-1:0] :
                     (ry < SAT_LO) ? SAT_LO[DATA_W-1:0] : ry[DATA_W-1:0];
      ores.last   <= flast;
      ores.clip   <= cx | cy;
    end
  end

  assign out_valid = ov;
  assign out_res   = ores;

endmodule
`default_nettype wire

FILE: rtl/rotary_position_embedding_top.sv
// Rotary position embedding (half-split pairs): one pair in, one rotated pair out, each
// clock while the skid register is empty. Fully pipelined: dividend product, exponent
// division, exp2 multiply chain, angle path, CORDIC steps, gain and saturation, output
// register. A skid register behind the output parks one result while m_axis_tready is
// low; s_axis_tready drops only while the skid register is full. The user writes
// rotary_dims and theta_log2 through cfg_* only while no item is in flight; the block
// does not enforce it. Odd rotary_dims is rounded down, values are clamped to 2..128.
`default_nettype none
`include "assert_macros.svh"
module rotary_position_embedding_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // position[15:0], pair_index[21:16], first_value[37:22], second_value[53:38], zero pad
  input  logic [55:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // first_rotated[15:0], second_rotated[31:16]
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast,
  // clipped[0]
  output logic [0:0]  m_axis_tuser,
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_index,
  input  logic [20:0] cfg_data
);
  import rope_pkg::*;

  logic [DIMS_W-1:0]  dims;
  logic [THETA_W-1:0] theta;
  logic [HALF_W-1:0]  half_raw;
  logic [HALF_W-1:0]  half;

  logic       en;
  rope_side_t in_side;

  logic       dv;
  rope_side_t dside;
  logic [E_W-1:0] de;
  logic       xv;
  rope_side_t xside;
  logic [M_W-1:0] xm;
  logic [EINT_W-1:0] xeint;
  logic       av;
  rope_vec_t  avec;
  logic       tail_v;
  rope_res_t  tail_res;

  logic      ov;
  logic      sv;
  rope_res_t od;
  rope_res_t sd;
  logic      in_fire;
  logic      out_fire;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dims  <= RESET_DIMS;
      theta <= RESET_THETA;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ROTARY_DIMS: dims  <= cfg_data[DIMS_W-1:0];
        CFG_THETA_LOG2:  theta <= cfg_data[THETA_W-1:0];
        default: ;
      endcase
    end
  end

  // half the rotated dimensions, clamped
  assign half_raw = HALF_W'(dims[DIMS_W-1:1]);
  assign half     = (half_raw == '0) ? HALF_W'(1) :
                    (half_raw > HALF_W'(MAX_HALF)) ? HALF_W'(MAX_HALF) : half_raw;

  // input unpacking
  assign en           = ~sv;
  assign s_axis_tready = en;
  assign in_side.pos  = s_axis_tdata[15:0];
  assign in_side.a    = s_axis_tdata[37:22];
  assign in_side.b    = s_axis_tdata[53:38];
  assign in_side.last = s_axis_tlast;

  rope_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_axis_tvalid),
    .in_side   (in_side),
    .in_index  (s_axis_tdata[21:16]),
    .theta     (theta),
    .half      (half),
    .out_valid (dv),
    .out_side  (dside),
    .out_e     (de)
  );

  rope_exp2 u_exp2 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (dv),
    .in_side   (dside),
    .in_e      (de),
    .out_valid (xv),
    .out_side  (xside),
    .out_m     (xm),
    .out_eint  (xeint)
  );

  rope_angle u_angle (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (xv),
    .in_side   (xside),
    .in_m      (xm),
    .in_eint   (xeint),
    .out_valid (av),
    .out_vec   (avec)
  );

  rope_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (av),
    .in_vec    (avec),
    .out_valid (tail_v),
    .out_res   (tail_res)
  );

  // output register with skid stage
  assign in_fire  = tail_v & ~sv;
  assign out_fire = ov & m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (~ov | out_fire) begin
      if (sv) begin
        sv <= 1'b0;
        ov <= 1'b1;
      end else begin
        ov <= in_fire;
      end
    end else if (in_fire) begin
      sv <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (~ov | out_fire) begin
      if (sv) begin
        od <= sd;
      end else if (in_fire) begin
        od <= tail_res;
      end
    end else if (in_fire) begin
      sd <= tail_res;
    end
  end

  assign m_axis_tvalid   = ov;
  assign m_axis_tdata    = {od.second, od.first};
  assign m_axis_tlast    = od.last;
  assign m_axis_tuser[0] = od.clip;

  `RASSERT(a_skid_needs_out, clk, rst, sv |-> ov)
  `RASSERT_NEXT(a_skid_drains, clk, rst, sv && m_axis_tready, !sv)
  `RASSERT_NEXT(a_tail_parked, clk, rst, ov && !m_axis_tready && tail_v && !sv, sv)

endmodule
`default_nettype wire
